[rtl/core/wgm_pkg.sv]
// Shared types, constants and helper functions for the wildcard glob matcher.
`timescale 1ns / 1ps
`default_nettype none
package wgm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int NPOS        = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(NPOS);
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LVL_N       = $clog2(NPOS);

  localparam logic [7:0] STAR_CODE  = 8'd42;
  localparam logic [7:0] QUERY_CODE = 8'd63;
  localparam logic [7:0] UPPER_A    = 8'd65;
  localparam logic [7:0] UPPER_Z    = 8'd90;
  localparam logic [7:0] LOWER_A    = 8'd97;
  localparam logic [7:0] LOWER_Z    = 8'd122;
  localparam logic [7:0] CASE_GAP   = 8'd32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // one decoded word, already qualified by the handshake; zero bytes dropped
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       text;
    logic       finish;
    logic [7:0] ch;
  } cmd_t;

  // per-position view of the stored pattern
  typedef struct packed {
    logic [PATTERN_MAX-1:0] live;
    logic [PATTERN_MAX-1:0] star;
    logic [PATTERN_MAX-1:0] hit;
    logic [LEN_W-1:0]       len;
    logic                   ovf;
  } pat_view_t;

  function automatic logic [7:0] fold_letter(input logic [7:0] c);
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic byte_match(input logic [7:0] pat, input logic [7:0] txt,
                                      input logic ic);
    logic [7:0] a;
    logic [7:0] b;
    a = fold_letter(pat);
    b = fold_letter(txt);
    if (pat == QUERY_CODE || pat == txt) begin
      return 1'b1;
    end
    return ic && a >= LOWER_A && a <= LOWER_Z && a == b;
  endfunction

  // star at i active makes i+1 active, chained; log-depth prefix network
  function automatic logic [NPOS-1:0] star_closure(input logic [NPOS-1:0] vec,
                                                   input logic [PATTERN_MAX-1:0] star);
    logic [NPOS-1:0] g;
    logic [NPOS-1:0] p;
    logic [NPOS-1:0] g_n;
    logic [NPOS-1:0] p_n;
    int d;
    g = vec;
    p = {star, 1'b0};
    for (int lvl = 0; lvl < LVL_N; lvl++) begin
      d   = 1 << lvl;
      g_n = g;
      p_n = p;
      for (int i = 0; i < NPOS; i++) begin
        if (i >= d) begin
          g_n[i] = g[i] | (p[i] & g[i-d]);
          p_n[i] = p[i] & p[i-d];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

endpackage
`default_nettype wire

[rtl/core/wildcard_glob_matcher.sv]
// Top level: input word register, pattern store, position tracker, result register.
//
// Input stream s_*: one word per item. s_tuser carries the opcode (clear
// pattern, append pattern byte, text byte, end of text), s_tdata the byte.
// Words with a zero byte for append or text are dropped without effect.
// Output stream m_*: one word per end-of-text word, m_tdata bit 0 is the
// match flag, bit 1 the pattern overflow flag.
// Config channel cfg_*: writes the ignore_case bit; always ready. Write it
// only while no word is in flight.
// Flow: a word is registered in the input register on acceptance and processed
// from there; an end-of-text word's result is registered in the result register
// and is then valid on m_*. Throughput: one word per cycle unless an end-of-text
// word is held (see Stall); the position vector updates combinationally between registers.
// Stall: a pending result waits in the result register; non-end words keep
// flowing, an end-of-text word holds in the input register until the result
// register frees, and s_tready drops meanwhile.
// Reset: empty pattern, no overflow, text state restarted, ignore_case 0,
// both registers empty.
`timescale 1ns / 1ps
`default_nettype none
module wildcard_glob_matcher (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] char_code
  input  wire logic [1:0] s_tuser,   // [1:0] opcode
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [0] matched, [1] pattern_overflow, [7:2] zero
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data   // ignore_case
);

  logic               in_valid;
  wgm_pkg::op_e       in_op;
  logic [7:0]         in_ch;
  logic               fire;
  logic               ignore_case;
  logic               out_valid;
  logic               out_matched;
  logic               out_ovf;
  logic               hit;
  wgm_pkg::cmd_t      cmd;
  wgm_pkg::pat_view_t view;

  assign fire      = in_valid && (in_op != wgm_pkg::OP_END || !out_valid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  assign cmd.clear  = fire && in_op == wgm_pkg::OP_CLEAR;
  assign cmd.append = fire && in_op == wgm_pkg::OP_APPEND && in_ch != 8'd0;
  assign cmd.text   = fire && in_op == wgm_pkg::OP_TEXT && in_ch != 8'd0;
  assign cmd.finish = fire && in_op == wgm_pkg::OP_END;
  assign cmd.ch     = in_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op <= wgm_pkg::op_e'(s_tuser);
      in_ch <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_case <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      ignore_case <= cfg_data;
    end
  end

  wgm_pat_store u_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .ignore_case (ignore_case),
    .view        (view)
  );

  wgm_track u_track (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .view (view),
    .hit  (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_matched <= hit;
      out_ovf     <= view.ovf;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_ovf, out_matched};

`ifndef SYNTHESIS
  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.finish))
    else $error("result word without end-of-text word");

  a_match_excludes_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("match reported on overflowed pattern");

  a_end_waits_for_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !cmd.finish)
    else $error("end-of-text processed while result stalled");

  a_len_bounded: assert property (@(posedge clk) disable iff (rst)
    view.len <= wgm_pkg::LEN_W'(wgm_pkg::PATTERN_MAX))
    else $error("pattern length beyond store");
`endif

endmodule
`default_nettype wire

[rtl/core/wgm_pat_store.sv]
// Pattern store: byte registers, length, overflow flag and per-position compare.
`timescale 1ns / 1ps
`default_nettype none
module wgm_pat_store (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wgm_pkg::cmd_t     cmd,
  input  wire logic              ignore_case,
  output wgm_pkg::pat_view_t     view
);

  logic [7:0]                   store [wgm_pkg::PATTERN_MAX];
  logic [wgm_pkg::LEN_W-1:0]    len;
  logic                         ovf;
  logic                         room;

  assign room = len < wgm_pkg::LEN_W'(wgm_pkg::PATTERN_MAX);

  always_ff @(posedge clk) begin
    if (cmd.append && room) begin
      store[len[wgm_pkg::IDX_W-1:0]] <= cmd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
    end else if (cmd.clear) begin
      len <= '0;
      ovf <= 1'b0;
    end else if (cmd.append) begin
      if (room) begin
        len <= len + wgm_pkg::LEN_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_comb begin
    view.len = len;
    view.ovf = ovf;
    for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
      view.live[i] = wgm_pkg::LEN_W'(i) < len;
      view.star[i] = view.live[i] && store[i] == wgm_pkg::STAR_CODE;
      view.hit[i]  = view.live[i] && !view.star[i] &&
                     wgm_pkg::byte_match(store[i], cmd.ch, ignore_case);
    end
  end

endmodule
`default_nettype wire

[rtl/core/wgm_track.sv]
// Active position vector: one update per text byte, match decision at end of text.
`timescale 1ns / 1ps
`default_nettype none
module wgm_track (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wgm_pkg::cmd_t      cmd,
  input  wire wgm_pkg::pat_view_t view,
  output logic                    hit
);

  logic [wgm_pkg::NPOS-1:0] active;
  logic [wgm_pkg::NPOS-1:0] cur;
  logic [wgm_pkg::NPOS-1:0] active_next;
  logic                     text_seen;
  logic                     restart;

  assign cur     = wgm_pkg::star_closure(active, view.star);
  assign restart = cmd.clear || cmd.append || cmd.finish;
  assign hit     = text_seen && !view.ovf && cur[view.len];

  always_comb begin
    active_next = '0;
    for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
      active_next[i]   = active_next[i] | (cur[i] & view.star[i]);
      active_next[i+1] = cur[i] & view.hit[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      active    <= wgm_pkg::NPOS'(1);
      text_seen <= 1'b0;
    end else if (cmd.text) begin
      active    <= active_next;
      text_seen <= 1'b1;
    end
  end

endmodule
`default_nettype wire
